// ===== hdl/ddd_pkg.sv =====
// Package with the types, constants and calendar helpers of the date difference block.
`timescale 1ns / 1ps
`default_nettype none

package ddd_pkg;

	// Field widths.
	localparam int unsigned DayW = 5;
	localparam int unsigned MonW = 4;
	localparam int unsigned YearW = 14;
	localparam int unsigned CountW = 22;
	localparam int unsigned StatW = 2;
	localparam int unsigned Rem400W = 9;

	// Calendar constants.
	localparam logic [YearW-1:0] YEAR_MAX = YearW'(9999);
	localparam logic [YearW-1:0] CYCLE_400 = YearW'(400);
	localparam logic [Rem400W-1:0] REM_LAST = Rem400W'(399);
	localparam logic [MonW-1:0] MONTH_FIRST = MonW'(1);
	localparam logic [MonW-1:0] MONTH_LAST = MonW'(12);

	// Status codes.
	localparam logic [StatW-1:0] ST_OK = 2'd0;
	localparam logic [StatW-1:0] ST_ORDER = 2'd1;
	localparam logic [StatW-1:0] ST_INVALID = 2'd2;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD_L,
		S_MOD_E,
		S_CHECK,
		S_WALK
	} ddd_state_t;

	// Leap year from the two low year bits and the year modulo 400.
	function automatic logic is_leap(input logic [1:0] y_lo, input logic [Rem400W-1:0] r400);
		is_leap = (y_lo == 2'd0) && (r400 != Rem400W'(100)) && (r400 != Rem400W'(200))
			&& (r400 != Rem400W'(300));
	endfunction

	// Month length; zero for a month code that names no month.
	function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m, input logic leap);
		unique case (m) inside
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = DayW'(31);
			4'd4, 4'd6, 4'd9, 4'd11: month_len = DayW'(30);
			4'd2: month_len = leap ? DayW'(29) : DayW'(28);
			default: month_len = DayW'(0);
		endcase
	endfunction

endpackage

`default_nettype wire

// ===== hdl/date_difference_days.sv =====
// Days between two Gregorian dates, found by a month-by-month walk under a small sequencer.
// The run time grows with the two year values, through the modulo passes, and with the number
// of month boundaries between the two dates (at most about 120000), one walk step each.
// Invalid or misordered inputs finish after the two modulo passes and the check state.
// Throughput: one transaction at a time; busy stays high until the result cycle, and the next
// start is taken in the cycle that done is shown. Results cannot be stalled.
// Reset: arst_n clears the sequencer and the done strobe asynchronously.
`timescale 1ns / 1ps
`default_nettype none

module date_difference_days
	import ddd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [DayW-1:0]   later_day,
	input  wire logic [MonW-1:0]   later_month,
	input  wire logic [YearW-1:0]  later_year,
	input  wire logic [DayW-1:0]   earlier_day,
	input  wire logic [MonW-1:0]   earlier_month,
	input  wire logic [YearW-1:0]  earlier_year,
	output logic                   done,
	output logic [CountW-1:0]      day_count,
	output logic [StatW-1:0]       status
);

	ddd_state_t state_q, state_d;
	logic done_q, done_d;

	// Later date, walk position, remainder unit and running count.
	logic [DayW-1:0] ld_q, cd_q, cd_d;
	logic [MonW-1:0] lm_q, cm_q, cm_d;
	logic [YearW-1:0] ly_q, cy_q, cy_d;
	logic [YearW-1:0] rem_q, rem_d;
	logic [Rem400W-1:0] lr400_q, lr400_d;
	logic [CountW-1:0] count_q, count_d;
	logic [StatW-1:0] status_q, status_d;

	logic accept;
	logic rem_ge;
	logic [Rem400W-1:0] cr400;
	logic l_leap, c_leap;
	logic [DayW-1:0] l_len, c_len;
	logic l_ok, c_ok, order_bad, at_end;
	logic [CountW-1:0] addend;

	assign accept = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign day_count = count_q;
	assign status = status_q;

	// Shared remainder unit and month length lookups.
	assign rem_ge = (rem_q >= CYCLE_400);
	assign cr400 = rem_q[Rem400W-1:0];
	assign l_leap = is_leap(ly_q[1:0], lr400_q);
	assign c_leap = is_leap(cy_q[1:0], cr400);
	assign l_len = month_len(lm_q, l_leap);
	assign c_len = month_len(cm_q, c_leap);

	// Date validity and ordering.
	assign l_ok = (ly_q != '0) && (ly_q <= YEAR_MAX) && (ld_q != '0) && (ld_q <= l_len);
	assign c_ok = (cy_q != '0) && (cy_q <= YEAR_MAX) && (cd_q != '0) && (cd_q <= c_len);
	assign order_bad = {ly_q, lm_q, ld_q} < {cy_q, cm_q, cd_q};
	assign at_end = (cy_q == ly_q) && (cm_q == lm_q);

	// Days added this walk step: rest of the month, or the final day difference.
	always_comb begin
		if (at_end) begin
			addend = CountW'(ld_q) - CountW'(cd_q);
		end else begin
			addend = CountW'(c_len) - CountW'(cd_q) + CountW'(1);
		end
	end

	// Next state and datapath control.
	always_comb begin
		state_d = state_q;
		done_d = 1'b0;
		cd_d = cd_q;
		cm_d = cm_q;
		cy_d = cy_q;
		rem_d = rem_q;
		lr400_d = lr400_q;
		count_d = count_q;
		status_d = status_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cd_d = earlier_day;
					cm_d = earlier_month;
					cy_d = earlier_year;
					rem_d = later_year;
					state_d = S_MOD_L;
				end
			end
			S_MOD_L: begin
				if (rem_ge) begin
					rem_d = rem_q - CYCLE_400;
				end else begin
					lr400_d = rem_q[Rem400W-1:0];
					rem_d = cy_q;
					state_d = S_MOD_E;
				end
			end
			S_MOD_E: begin
				if (rem_ge) begin
					rem_d = rem_q - CYCLE_400;
				end else begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				count_d = '0;
				if (!l_ok || !c_ok) begin
					status_d = ST_INVALID;
					done_d = 1'b1;
					state_d = S_IDLE;
				end else if (order_bad) begin
					status_d = ST_ORDER;
					done_d = 1'b1;
					state_d = S_IDLE;
				end else begin
					status_d = ST_OK;
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				count_d = count_q + addend;
				if (at_end) begin
					done_d = 1'b1;
					state_d = S_IDLE;
				end else begin
					cd_d = DayW'(1);
					if (cm_q == MONTH_LAST) begin
						cm_d = MONTH_FIRST;
						cy_d = cy_q + YearW'(1);
						rem_d = (cr400 == REM_LAST) ? '0 : rem_q + YearW'(1);
					end else begin
						cm_d = cm_q + MonW'(1);
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= done_d;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			ld_q <= later_day;
			lm_q <= later_month;
			ly_q <= later_year;
		end
		cd_q <= cd_d;
		cm_q <= cm_d;
		cy_q <= cy_d;
		rem_q <= rem_d;
		lr400_q <= lr400_d;
		count_q <= count_d;
		status_q <= status_d;
	end

	// A result only appears once the sequencer has returned to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done raised while busy");

	// A failed transaction always reports a zero count.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |-> (day_count == '0))
		else $error("nonzero count with error status");

	// Only defined status codes are reported.
	a_stat_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((status == ST_OK) || (status == ST_ORDER) || (status == ST_INVALID)))
		else $error("undefined status code");

	// An accepted transaction makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not start");

	// The walk never passes the later month.
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> !order_bad)
		else $error("walk passed the later date");

endmodule

`default_nettype wire

// ===== verif/tb_date_difference_days.sv =====
// Self-checking testbench for the date difference block: directed and random date pairs.
`timescale 1ns / 1ps
`default_nettype none

module tb_date_difference_days;
	import ddd_pkg::*;

	typedef struct packed {
		logic [DayW-1:0]  day;
		logic [MonW-1:0]  month;
		logic [YearW-1:0] year;
	} cal_date_t;

	typedef struct packed {
		cal_date_t later;
		cal_date_t earlier;
	} date_pair_t;

	typedef struct packed {
		logic [CountW-1:0] count;
		logic [StatW-1:0]  stat;
	} span_result_t;

	localparam int unsigned ITEMS_PER_PHASE = 19;
	localparam int unsigned SETTLE_CYCLES = 64;
	localparam int unsigned MAX_SHOWN = 10;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [DayW-1:0]   later_day = '0;
	logic [MonW-1:0]   later_month = '0;
	logic [YearW-1:0]  later_year = '0;
	logic [DayW-1:0]   earlier_day = '0;
	logic [MonW-1:0]   earlier_month = '0;
	logic [YearW-1:0]  earlier_year = '0;
	logic              busy;
	logic              done;
	logic [CountW-1:0] day_count;
	logic [StatW-1:0]  status;

	// Gregorian calendar arithmetic used to predict the block.
	function automatic bit leap_year(input int unsigned y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11: return 30;
			2: return leap_year(y) ? 29 : 28;
			default: return 0;
		endcase
	endfunction

	// An unknown month has length zero, so it fails the day test as well.
	function automatic bit date_valid(input cal_date_t dt);
		if (dt.year < 1 || dt.year > YEAR_MAX)
			return 1'b0;
		return dt.day >= 1 && dt.day <= days_in_month(dt.month, dt.year);
	endfunction

	// Days since the start of the calendar, counting 1/1/1 as day one.
	function automatic int unsigned serial_day(input cal_date_t dt);
		int unsigned p;
		int unsigned n;
		p = dt.year - 1;
		n = 365 * p + p / 4 - p / 100 + p / 400 + dt.day;
		for (int unsigned mm = 1; mm < dt.month; mm++)
			n += days_in_month(mm, dt.year);
		return n;
	endfunction

	// Invalid dates take precedence over a reversed order.
	function automatic span_result_t expected_span(input date_pair_t pr);
		span_result_t r;
		int unsigned a;
		int unsigned b;
		r.count = '0;
		r.stat = ST_OK;
		if (!date_valid(pr.later) || !date_valid(pr.earlier)) begin
			r.stat = ST_INVALID;
		end else begin
			a = serial_day(pr.later);
			b = serial_day(pr.earlier);
			if (a < b)
				r.stat = ST_ORDER;
			else
				r.count = CountW'(a - b);
		end
		return r;
	endfunction

	// Holds the day spans still owed by the block, oldest first.
	class day_span_tracker;
		span_result_t awaited[$];
		int unsigned failures = 0;
		int unsigned reported = 0;

		function void note_request(input date_pair_t pr);
			awaited.push_back(expected_span(pr));
		endfunction

		function void check_result(input logic [CountW-1:0] count, input logic [StatW-1:0] stat);
			span_result_t want;
			if (awaited.size() == 0) begin
				failures++;
				if (reported < MAX_SHOWN) begin
					reported++;
					$display("unexpected result: count %0d status %0d", count, stat);
				end
				return;
			end
			want = awaited.pop_front();
			if (count !== want.count || stat !== want.stat) begin
				failures++;
				if (reported < MAX_SHOWN) begin
					reported++;
					$display("mismatch: expected count %0d status %0d, got count %0d status %0d",
						want.count, want.stat, count, stat);
				end
			end
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction
	endclass

	day_span_tracker spans = new();

	date_difference_days i_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Score each accepted transaction and each result strobe at the clock edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				spans.check_result(day_count, status);
			if (start && !busy)
				spans.note_request(date_pair_t'({later_day, later_month, later_year,
					earlier_day, earlier_month, earlier_year}));
		end
	end

	function automatic date_pair_t pair_of(input int unsigned ld, input int unsigned lm,
			input int unsigned ly, input int unsigned ed, input int unsigned em,
			input int unsigned ey);
		date_pair_t pr;
		pr.later = '{DayW'(ld), MonW'(lm), YearW'(ly)};
		pr.earlier = '{DayW'(ed), MonW'(em), YearW'(ey)};
		return pr;
	endfunction

	function automatic cal_date_t random_date(input int unsigned y);
		cal_date_t dt;
		dt.year = YearW'(y);
		dt.month = MonW'($urandom_range(12, 1));
		dt.day = DayW'($urandom_range(days_in_month(dt.month, y), 1));
		return dt;
	endfunction

	// Two valid dates at most max_span years apart, put in order or deliberately reversed.
	function automatic date_pair_t random_pair(input int unsigned max_span, input bit reversed);
		date_pair_t pr;
		cal_date_t tmp;
		int unsigned ly;
		int unsigned gap;
		ly = $urandom_range(YEAR_MAX, 1);
		gap = $urandom_range((ly - 1 < max_span) ? ly - 1 : max_span, 0);
		pr.later = random_date(ly);
		pr.earlier = random_date(ly - gap);
		if ((serial_day(pr.later) < serial_day(pr.earlier)) != reversed) begin
			tmp = pr.later;
			pr.later = pr.earlier;
			pr.earlier = tmp;
		end
		return pr;
	endfunction

	// Raw field values; a pair that happens to be valid is spoiled so that it stays cheap.
	function automatic date_pair_t random_noise();
		date_pair_t pr;
		pr.later.day = DayW'($urandom_range(31, 0));
		pr.later.month = MonW'($urandom_range(15, 0));
		pr.later.year = YearW'($urandom_range(16383, 0));
		pr.earlier.day = DayW'($urandom_range(31, 0));
		pr.earlier.month = MonW'($urandom_range(15, 0));
		pr.earlier.year = YearW'($urandom_range(16383, 0));
		if (date_valid(pr.later) && date_valid(pr.earlier))
			pr.later.day = '0;
		return pr;
	endfunction

	// Present one transaction and hold it until the block takes it.
	task automatic send_dates(input date_pair_t pr);
		start <= 1'b1;
		later_day <= pr.later.day;
		later_month <= pr.later.month;
		later_year <= pr.later.year;
		earlier_day <= pr.earlier.day;
		earlier_month <= pr.earlier.month;
		earlier_year <= pr.earlier.year;
		do @(posedge clk); while (busy);
	endtask

	task automatic sender_idle(input int unsigned pct);
		if ($urandom_range(99, 0) < pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99, 0) < pct);
		end
	endtask

	task automatic wait_all_results();
		start <= 1'b0;
		do @(posedge clk); while (spans.pending() != 0);
	endtask

	// Reset, directed cases, then random phases with different sender idling.
	initial begin
		int unsigned idle_pct [4];
		int unsigned pick;
		int unsigned n;
		date_pair_t pr;
		idle_pct = '{0, 83, 0, 13};
		n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_dates(pair_of(1, 1, 1, 1, 1, 1));
		send_dates(pair_of(31, 12, 9999, 1, 1, 1));
		send_dates(pair_of(1, 1, 1, 31, 12, 9999));
		send_dates(pair_of(1, 3, 2000, 28, 2, 2000));
		send_dates(pair_of(29, 2, 2000, 1, 1, 2000));
		send_dates(pair_of(1, 3, 1900, 29, 2, 1900));
		send_dates(pair_of(29, 2, 2004, 28, 2, 2004));
		send_dates(pair_of(1, 3, 2001, 29, 2, 2001));
		send_dates(pair_of(0, 5, 2010, 1, 5, 2010));
		send_dates(pair_of(31, 4, 2010, 1, 4, 2010));
		send_dates(pair_of(1, 5, 2010, 31, 6, 2010));
		send_dates(pair_of(1, 0, 2010, 1, 1, 2010));
		send_dates(pair_of(1, 13, 2010, 1, 1, 2010));
		send_dates(pair_of(1, 1, 2010, 1, 15, 2010));
		send_dates(pair_of(1, 1, 0, 1, 1, 1));
		send_dates(pair_of(1, 1, 10000, 1, 1, 9999));
		send_dates(pair_of(31, 15, 16383, 31, 15, 16383));
		send_dates(pair_of(0, 1, 1, 1, 1, 2));
		send_dates(pair_of(1, 3, 2024, 2, 3, 2024));
		send_dates(pair_of(31, 12, 2023, 1, 1, 2024));
		send_dates(pair_of(31, 1, 2023, 1, 1, 2023));
		send_dates(pair_of(1, 1, 2024, 31, 12, 2023));
		send_dates(pair_of(31, 12, 9999, 1, 1, 9999));
		send_dates(pair_of(1, 1, 2, 31, 12, 1));
		send_dates(pair_of(0, 0, 0, 0, 0, 0));
		wait_all_results();

		// Mostly short ordered spans, a few long ones, some reversed pairs and raw noise.
		for (int unsigned phase = 0; phase < 4; phase++) begin
			for (int unsigned k = 0; k < ITEMS_PER_PHASE; k++) begin
				sender_idle(idle_pct[phase]);
				pick = $urandom_range(99, 0);
				if (n % 40 == 20)
					pr = random_pair(YEAR_MAX - 1, 1'b0);
				else if (pick < 70)
					pr = random_pair(2, 1'b0);
				else if (pick < 80)
					pr = random_pair(40, 1'b0);
				else if (pick < 88)
					pr = random_pair(40, 1'b1);
				else
					pr = random_noise();
				send_dates(pr);
				if (phase == 1 && k == 12)
					wait_all_results();
				n++;
			end
		end

		wait_all_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (spans.failures == 0 && spans.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog well above the slowest legal run.
	initial begin
		#36_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/ddd_pkg.sv
hdl/date_difference_days.sv
verif/tb_date_difference_days.sv
